/* hw/rtl/scfd_pkg.sv */
// Package: shared constants, payload structs and controller/datapath interface types.
`default_nettype none
package scfd_pkg;

  // Store geometry
  localparam int SAMPLE_DEPTH = 1024;
  localparam int ADDR_W       = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);
  localparam int SAMPLE_W     = 192;
  localparam int STORED_W     = 11;

  // Frame layout
  localparam int FRAME_LEN    = 28;
  localparam int BIDX_W       = $clog2(FRAME_LEN);
  localparam int DATA_FIRST   = 2;
  localparam int DATA_LAST    = 25;
  localparam int CSUM_POS     = 26;
  localparam logic [7:0] SYNC0 = 8'hAA;
  localparam logic [7:0] SYNC1 = 8'h55;
  localparam logic [7:0] TAIL  = 8'h7F;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_REQ   = 2'd2,
    OP_SEND  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    NOTE_NONE      = 2'd0,
    NOTE_STARTED   = 2'd1,
    NOTE_CAPTURED  = 2'd2,
    NOTE_SENT      = 2'd3
  } note_t;

  typedef struct packed {
    op_t                op;
    logic [31:0]        time_stamp;
    logic [31:0]        roll_bits;
    logic [31:0]        pitch_bits;
    logic [31:0]        yaw_bits;
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
    logic signed [15:0] speed_c;
    logic signed [15:0] speed_d;
  } in_t;

  typedef struct packed {
    logic [7:0]          frame_byte;
    logic                byte_valid;
    logic                last;
    note_t               notify;
    logic                recording_flag;
    logic                ready_flag;
    logic                sending_flag;
    logic [STORED_W-1:0] stored_count;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic emit_single;
    logic emit_byte;
  } scfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_go;
    logic slot_free;
    logic byte_last;
  } scfd_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/sample_capture_frame_dumper.sv */
// Top level: sample capture engine with framed byte dump.
// Requests are taken one at a time. A sample tick, start, send request or a
// send step that emits no frame goes through accept, execute and emit steps,
// the last loading its single result into the output register. A send step
// that emits a frame executes and issues the read of the sample memory's
// registered port, then moves its 28 frame bytes from the serializer into
// the output register, one frame byte per cycle, longer while out_stall
// holds. The input side takes a new request as soon as the previous one has
// loaded its last result, even while that result still waits in the output
// register. The sample store is not cleared after reset; there is no
// clearing pass.
`default_nettype none
module sample_capture_frame_dumper
  import scfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  scfd_cmd_t cmd;
  scfd_sts_t sts;

  // Sequencer
  scfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // State, memory and serializer
  scfd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hw/rtl/scfd_ctrl.sv */
// Controller: sequences accept, execute and result emission for one request at a time.
`default_nettype none
module scfd_ctrl
  import scfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire scfd_sts_t sts,
  output scfd_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SINGLE,
    S_FRAME
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.frame_go ? S_FRAME : S_SINGLE;
      end
      S_SINGLE: begin
        if (sts.slot_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_FRAME: begin
        if (sts.slot_free) begin
          cmd.emit_byte = 1'b1;
          if (sts.byte_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

/* hw/rtl/scfd_datapath.sv */
// Datapath: capture state, sample memory, frame serializer and output register.
`default_nettype none
module scfd_datapath
  import scfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_t       in_data,
  input  wire scfd_cmd_t cmd,
  output scfd_sts_t      sts,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_t           out_data
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SAMPLE_DEPTH);

  // Request held while it executes
  in_t item_r;

  // Capture and readback state
  logic             rec_r, rec_nxt;
  logic             rdy_r, rdy_nxt;
  logic             send_r, send_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cursor_r, cursor_nxt;
  note_t            note_r, note_nxt;

  // Sample memory
  logic [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
  logic [SAMPLE_W-1:0] rd_r;
  logic [SAMPLE_W-1:0] wdata;
  logic                mem_we;
  logic                mem_re;

  // Serializer
  logic [BIDX_W-1:0] bidx_r;
  logic [7:0]        xor_r;
  logic [BIDX_W-1:0] boff;
  logic [7:0]        data_byte;
  logic [7:0]        cur_byte;
  logic              is_data;

  // Output register
  logic out_valid_r;
  out_t out_r;

  logic [CNT_W-1:0] cursor_inc;
  logic             frame_go;

  assign wdata = {item_r.speed_d, item_r.speed_c, item_r.speed_b, item_r.speed_a,
                  item_r.yaw_bits, item_r.pitch_bits, item_r.roll_bits,
                  item_r.time_stamp};

  assign cursor_inc = cursor_r + 1'b1;
  assign frame_go   = (item_r.op == OP_SEND) && send_r &&
                      (cursor_r < count_r) && (cursor_r < DEPTH_C);

  // Step update of the capture state
  always_comb begin
    rec_nxt    = rec_r;
    rdy_nxt    = rdy_r;
    send_nxt   = send_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    note_nxt   = NOTE_NONE;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (item_r.op)
      OP_TICK: begin
        if (rec_r) begin
          if (count_r >= DEPTH_C) begin
            rec_nxt  = 1'b0;
            rdy_nxt  = 1'b1;
            note_nxt = NOTE_CAPTURED;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      OP_START: begin
        rec_nxt    = 1'b1;
        count_nxt  = '0;
        rdy_nxt    = 1'b0;
        send_nxt   = 1'b0;
        cursor_nxt = '0;
        note_nxt   = NOTE_STARTED;
      end
      OP_REQ: begin
        if (rdy_r && !send_r) begin
          cursor_nxt = '0;
          send_nxt   = 1'b1;
        end
      end
      OP_SEND: begin
        if (send_r) begin
          if (frame_go) begin
            mem_re     = 1'b1;
            cursor_nxt = cursor_inc;
            if (cursor_inc >= count_r) begin
              send_nxt = 1'b0;
              note_nxt = NOTE_SENT;
            end
          end else begin
            send_nxt = 1'b0;
            note_nxt = NOTE_SENT;
          end
        end
      end
      default: begin
        note_nxt = NOTE_NONE;
      end
    endcase
  end

  // Item register
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r    <= 1'b0;
      rdy_r    <= 1'b0;
      send_r   <= 1'b0;
      count_r  <= '0;
      cursor_r <= '0;
      note_r   <= NOTE_NONE;
    end else if (cmd.exec) begin
      rec_r    <= rec_nxt;
      rdy_r    <= rdy_nxt;
      send_r   <= send_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      note_r   <= note_nxt;
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[count_r[ADDR_W-1:0]] <= wdata;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_re) begin
      rd_r <= mem[cursor_r[ADDR_W-1:0]];
    end
  end

  // Byte select for the current frame position
  assign boff      = bidx_r - BIDX_W'(DATA_FIRST);
  assign data_byte = rd_r[{boff, 3'b000} +: 8];
  assign is_data   = (bidx_r >= BIDX_W'(DATA_FIRST)) && (bidx_r <= BIDX_W'(DATA_LAST));

  always_comb begin
    if (bidx_r == BIDX_W'(0)) begin
      cur_byte = SYNC0;
    end else if (bidx_r == BIDX_W'(1)) begin
      cur_byte = SYNC1;
    end else if (is_data) begin
      cur_byte = data_byte;
    end else if (bidx_r == BIDX_W'(CSUM_POS)) begin
      cur_byte = xor_r;
    end else begin
      cur_byte = TAIL;
    end
  end

  // Byte counter and running checksum
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      bidx_r <= '0;
      xor_r  <= '0;
    end else if (cmd.emit_byte) begin
      bidx_r <= bidx_r + 1'b1;
      if (is_data) begin
        xor_r <= xor_r ^ data_byte;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit_single || cmd.emit_byte) begin
      out_r.recording_flag <= rec_r;
      out_r.ready_flag     <= rdy_r;
      out_r.sending_flag   <= send_r;
      out_r.stored_count   <= STORED_W'(count_r);
      if (cmd.emit_byte) begin
        out_r.frame_byte <= cur_byte;
        out_r.byte_valid <= 1'b1;
        out_r.last       <= sts.byte_last;
        out_r.notify     <= sts.byte_last ? note_r : NOTE_NONE;
      end else begin
        out_r.frame_byte <= 8'h00;
        out_r.byte_valid <= 1'b0;
        out_r.last       <= 1'b1;
        out_r.notify     <= note_r;
      end
    end
  end

  assign sts.frame_go  = frame_go;
  assign sts.slot_free = !out_valid_r || !out_stall;
  assign sts.byte_last = (bidx_r == BIDX_W'(FRAME_LEN - 1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("sample count beyond store depth");
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    send_r |-> (cursor_r <= count_r)) else $error("read cursor passed count");
  a_rec_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_r && rdy_r)) else $error("recording and ready both set");
  a_send_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    send_r |-> rdy_r) else $error("sending without a finished capture");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_single || cmd.emit_byte) |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a waiting result");
`endif

endmodule
`default_nettype wire

/* sim/sample_capture_frame_dumper_test.sv */
// Self-checking testbench for the sample capture engine and its framed byte dump.
module sample_capture_frame_dumper_test
  import scfd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks capture state and the queue of output records still owed by the block
  class capture_scoreboard;
    in_t         captured [SAMPLE_DEPTH];
    bit          recording;
    bit          ready;
    bit          sending;
    int unsigned fill;
    int unsigned cursor;
    out_t        awaited [$];
    int          errors;
    int          requests;
    int          results_checked;
    int          frames_built;
    int          captures_done;
    int          dumps_done;

    // Output record carrying the flags as they stand after the request
    function out_t flags_out(logic [7:0] b, bit valid, bit is_last, note_t note);
      out_t o;
      o.frame_byte     = b;
      o.byte_valid     = valid;
      o.last           = is_last;
      o.notify         = note;
      o.recording_flag = recording;
      o.ready_flag     = ready;
      o.sending_flag   = sending;
      o.stored_count   = fill[STORED_W-1:0];
      return o;
    endfunction

    // Advance the capture state for one accepted request, queue what it owes
    function void note_request(in_t req);
      logic [7:0] frame [FRAME_LEN];
      logic [7:0] csum;
      in_t        s;
      note_t      note;
      int         k;
      note = NOTE_NONE;
      requests++;
      case (req.op)
        OP_TICK: begin
          if (recording) begin
            if (fill >= SAMPLE_DEPTH) begin
              // store full: this tick closes the capture, nothing stored
              recording = 1'b0;
              ready     = 1'b1;
              note      = NOTE_CAPTURED;
              captures_done++;
            end else begin
              captured[fill] = req;
              fill++;
            end
          end
        end
        OP_START: begin
          recording = 1'b1;
          fill      = 0;
          ready     = 1'b0;
          sending   = 1'b0;
          cursor    = 0;
          note      = NOTE_STARTED;
        end
        OP_REQ: begin
          if (ready && !sending) begin
            cursor  = 0;
            sending = 1'b1;
          end
        end
        OP_SEND: begin
          if (sending) begin
            if (cursor < fill && cursor < SAMPLE_DEPTH) begin
              s = captured[cursor];
              frame[0] = SYNC0;
              frame[1] = SYNC1;
              for (k = 0; k < 4; k++) begin
                frame[2 + k]  = s.time_stamp[8*k +: 8];
                frame[6 + k]  = s.roll_bits[8*k +: 8];
                frame[10 + k] = s.pitch_bits[8*k +: 8];
                frame[14 + k] = s.yaw_bits[8*k +: 8];
              end
              for (k = 0; k < 2; k++) begin
                frame[18 + k] = s.speed_a[8*k +: 8];
                frame[20 + k] = s.speed_b[8*k +: 8];
                frame[22 + k] = s.speed_c[8*k +: 8];
                frame[24 + k] = s.speed_d[8*k +: 8];
              end
              csum = 8'h00;
              for (k = DATA_FIRST; k <= DATA_LAST; k++) csum ^= frame[k];
              frame[CSUM_POS]    = csum;
              frame[FRAME_LEN-1] = TAIL;
              cursor++;
              // the frame that reaches the count ends the dump
              if (cursor >= fill) begin
                sending = 1'b0;
                note    = NOTE_SENT;
                dumps_done++;
              end
              for (k = 0; k < FRAME_LEN; k++)
                awaited.push_back(flags_out(frame[k], 1'b1, k == FRAME_LEN - 1,
                                            (k == FRAME_LEN - 1) ? note : NOTE_NONE));
              frames_built++;
              return;
            end
            sending = 1'b0;
            note    = NOTE_SENT;
          end
        end
      endcase
      awaited.push_back(flags_out(8'h00, 1'b0, 1'b1, note));
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      end
    endfunction

    // Match one accepted output record against the oldest owed one
    function void check_result(out_t got);
      out_t want;
      results_checked++;
      if (awaited.size() == 0) begin
        errors++;
        $error("output record with nothing owed: frame_byte 0x%0h notify %0d",
               got.frame_byte, got.notify);
        return;
      end
      want = awaited.pop_front();
      compare("frame_byte", 32'(want.frame_byte), 32'(got.frame_byte));
      compare("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
      compare("last", 32'(want.last), 32'(got.last));
      compare("notify", 32'(want.notify), 32'(got.notify));
      compare("recording_flag", 32'(want.recording_flag), 32'(got.recording_flag));
      compare("ready_flag", 32'(want.ready_flag), 32'(got.ready_flag));
      compare("sending_flag", 32'(want.sending_flag), 32'(got.sending_flag));
      compare("stored_count", 32'(want.stored_count), 32'(got.stored_count));
    endfunction
  endclass

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  capture_scoreboard sb = new();
  int calm_left;
  int holds_done;

  sample_capture_frame_dumper DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(13, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_t make_item(op_t op);
    in_t it;
    it.op         = op;
    it.time_stamp = rand_word();
    it.roll_bits  = rand_word();
    it.pitch_bits = rand_word();
    it.yaw_bits   = rand_word();
    it.speed_a    = rand_half();
    it.speed_b    = rand_half();
    it.speed_c    = rand_half();
    it.speed_d    = rand_half();
    return it;
  endfunction

  function automatic in_t fill_item(op_t op, logic [31:0] w, logic [15:0] h);
    in_t it;
    it.op         = op;
    it.time_stamp = w;
    it.roll_bits  = w;
    it.pitch_bits = w;
    it.yaw_bits   = w;
    it.speed_a    = h;
    it.speed_b    = h;
    it.speed_c    = h;
    it.speed_d    = h;
    return it;
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic push(input in_t req);
    int gap;
    bit stalled;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sb.note_request(req);
  endtask

  // Sender pause: nothing offered until every owed record is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  // One capture from start to full store, then a dump of dump_len frames
  task automatic capture_round(input int dump_len, input int aborts);
    int k;
    // short captures thrown away by a restart
    repeat (aborts) begin
      push(make_item(OP_START));
      repeat ($urandom_range(0, 30)) push(make_item(OP_TICK));
    end
    push(make_item(OP_START));
    for (k = 0; k < SAMPLE_DEPTH; k++) begin
      if ($urandom_range(0, 19) == 0)
        push(make_item($urandom_range(0, 1) ? OP_REQ : OP_SEND));
      push(make_item(OP_TICK));
    end
    push(make_item(OP_TICK));
    repeat ($urandom_range(0, 2)) push(make_item(OP_TICK));
    push(make_item(OP_REQ));
    for (k = 0; k < dump_len; k++) begin
      if ($urandom_range(0, 24) == 0)
        push(make_item($urandom_range(0, 1) ? OP_REQ : OP_TICK));
      push(make_item(OP_SEND));
    end
  endtask

  // Output checker: an output record is taken when valid and not stalled
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver stalls; two long holds force the block to back up into its input
  initial begin : result_sink
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ((holds_done == 0 && sb.results_checked >= 60) ||
          (holds_done == 1 && sb.results_checked >= 5000)) begin
        n = 300;
        holds_done++;
      end else begin
        n = idle_len();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle engine: tick, send step and send request all do nothing
    push(fill_item(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF));
    push(fill_item(OP_SEND, 32'hFFFF_FFFF, 16'hFFFF));
    push(fill_item(OP_REQ, 32'h0000_0000, 16'h0000));
    // capture a few extreme samples
    push(fill_item(OP_START, 32'h0000_0000, 16'h0000));
    push(fill_item(OP_TICK, 32'h0000_0000, 16'h0000));
    push(fill_item(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF));
    push(fill_item(OP_TICK, 32'h8000_0000, 16'h8000));
    push(fill_item(OP_TICK, 32'h7FFF_FFFF, 16'h7FFF));
    push(fill_item(OP_TICK, 32'hAAAA_AAAA, 16'h5555));
    push(fill_item(OP_TICK, 32'h5555_5555, 16'hAAAA));
    // send request and send step while recording are ignored
    push(make_item(OP_REQ));
    push(make_item(OP_SEND));
    // restart in the middle of a capture
    push(make_item(OP_START));
    push(make_item(OP_TICK));
    push(make_item(OP_TICK));
    push(make_item(OP_TICK));
    push(make_item(OP_START));
    drain();

    // full capture and complete dump, then the edges around its end,
    // including a restart that cuts a second dump short
    capture_round(SAMPLE_DEPTH, 2);
    push(make_item(OP_SEND));
    push(make_item(OP_REQ));
    push(make_item(OP_SEND));
    push(make_item(OP_SEND));
    push(make_item(OP_REQ));
    push(make_item(OP_SEND));
    push(make_item(OP_START));
    push(make_item(OP_REQ));
    push(make_item(OP_SEND));
    push(make_item(OP_TICK));
    push(make_item(OP_SEND));
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Covered %0d requests and %0d output records: %0d frames dumped,",
             sb.requests, sb.results_checked, sb.frames_built);
    $display("%0d captures filled, %0d dumps run to the end, %0d long receiver holds.",
             sb.captures_done, sb.dumps_done, holds_done);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin : watchdog
    #40000000;
    $error("run limit reached with %0d output records still owed", sb.awaited.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/scfd_pkg.sv
hw/rtl/scfd_ctrl.sv
hw/rtl/scfd_datapath.sv
hw/rtl/sample_capture_frame_dumper.sv
sim/sample_capture_frame_dumper_test.sv
